FILE: hdl/ifct_pkg.sv
// package for the ip flow counter table: widths, status and request codes
// no dependencies
`default_nettype none
package ifct_pkg;
  localparam int unsigned TableEntriesDef = 256;
  localparam int unsigned AddrW = 32;
  localparam int unsigned PktW = 32;
  localparam int unsigned ByteW = 48;
  localparam int unsigned LenW = 16;

  localparam logic [1:0] ReqPacket = 2'd0;
  localparam logic [1:0] ReqEntry = 2'd1;
  localparam logic [1:0] ReqTotals = 2'd2;

  localparam logic [1:0] StHit = 2'd0;
  localparam logic [1:0] StNew = 2'd1;
  localparam logic [1:0] StFull = 2'd2;
  localparam logic [1:0] StNone = 2'd3;

  localparam logic [PktW-1:0] PktMax = '1;
  localparam logic [ByteW-1:0] ByteMax = '1;

  function automatic logic [PktW-1:0] sat_pkt(input logic [PktW-1:0] a);
    logic [PktW:0] s;
    s = {1'b0, a} + {{PktW{1'b0}}, 1'b1};
    return s[PktW] ? PktMax : s[PktW-1:0];
  endfunction

  function automatic logic [ByteW-1:0] sat_byte(input logic [ByteW-1:0] a,
                                                input logic [LenW-1:0] b);
    logic [ByteW:0] s;
    s = {1'b0, a} + {{(ByteW+1-LenW){1'b0}}, b};
    return s[ByteW] ? ByteMax : s[ByteW-1:0];
  endfunction
endpackage
`default_nettype wire

FILE: hdl/ifct_table.sv
// one flow table: key/count memory, valid flags, sequential scan for match
// uses ifct_pkg
`default_nettype none
module ifct_table #(
  parameter int unsigned TableEntries = ifct_pkg::TableEntriesDef,
  localparam int unsigned IdxW = (TableEntries > 1) ? $clog2(TableEntries) : 1
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        upd_start_i,
  input  wire logic                        rd_start_i,
  input  wire logic [ifct_pkg::AddrW-1:0]  addr_i,
  input  wire logic [ifct_pkg::LenW-1:0]   len_i,
  input  wire logic [IdxW-1:0]             idx_i,
  output logic                             done_o,
  output logic [1:0]                       status_o,
  output logic                             ent_valid_o,
  output logic [ifct_pkg::AddrW-1:0]       ent_addr_o,
  output logic [ifct_pkg::PktW-1:0]        ent_pkts_o,
  output logic [ifct_pkg::ByteW-1:0]       ent_bytes_o
);
  localparam int unsigned EntW = ifct_pkg::AddrW + ifct_pkg::PktW + ifct_pkg::ByteW;
  typedef enum logic [2:0] {
    S_IDLE, S_SCAN, S_LAST, S_REREAD, S_WRITE, S_RDWAIT, S_RDOUT
  } state_e;

  logic [EntW-1:0] mem_q [TableEntries];
  logic [EntW-1:0] rdata_q;
  logic [TableEntries-1:0] valid_q;
  state_e state_q;
  logic [IdxW-1:0] ptr_q, rptr_q, free_q, hit_q;
  logic free_found_q, hit_found_q, scan_rd_q;
  logic [IdxW-1:0] rd_idx;
  logic rd_en;
  logic we;
  logic [IdxW-1:0] widx;
  logic [EntW-1:0] wdata;

  // scan reads one entry per cycle; free slots are found from valid flags
  // after the scan the hit slot is read again for the modify step
  assign rd_en = (state_q == S_SCAN) || (state_q == S_REREAD) || rd_start_i;
  assign rd_idx = rd_start_i ? idx_i : ((state_q == S_REREAD) ? hit_q : ptr_q);

  always_ff @(posedge clk_i) begin
    if (rd_en) rdata_q <= mem_q[rd_idx];
    if (we) mem_q[widx] <= wdata;
  end

  logic [ifct_pkg::AddrW-1:0] rkey;
  logic [ifct_pkg::PktW-1:0] rpkt;
  logic [ifct_pkg::ByteW-1:0] rbyte;
  assign {rkey, rpkt, rbyte} = rdata_q;

  always_comb begin
    we = 1'b0;
    widx = hit_q;
    wdata = {rkey, ifct_pkg::sat_pkt(rpkt), ifct_pkg::sat_byte(rbyte, len_i)};
    if (state_q == S_WRITE) begin
      if (hit_found_q) begin
        we = 1'b1;
      end else if (free_found_q) begin
        we = 1'b1;
        widx = free_q;
        wdata = {addr_i, {{(ifct_pkg::PktW-1){1'b0}}, 1'b1},
                 {(ifct_pkg::ByteW-ifct_pkg::LenW){1'b0}}, len_i};
      end
    end
  end

  logic match;
  assign match = scan_rd_q && valid_q[rptr_q] && (rkey == addr_i) && !hit_found_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      valid_q <= '0;
      ptr_q <= '0;
      rptr_q <= '0;
      free_q <= '0;
      hit_q <= '0;
      free_found_q <= 1'b0;
      hit_found_q <= 1'b0;
      scan_rd_q <= 1'b0;
      done_o <= 1'b0;
      status_o <= ifct_pkg::StNone;
      ent_valid_o <= 1'b0;
      ent_addr_o <= '0;
      ent_pkts_o <= '0;
      ent_bytes_o <= '0;
    end else begin
      done_o <= 1'b0;
      scan_rd_q <= (state_q == S_SCAN);
      rptr_q <= ptr_q;
      if (match) begin
        hit_found_q <= 1'b1;
        hit_q <= rptr_q;
      end
      if (scan_rd_q && !valid_q[rptr_q] && !free_found_q) begin
        free_found_q <= 1'b1;
        free_q <= rptr_q;
      end
      case (state_q)
        S_IDLE: begin
          if (upd_start_i) begin
            ptr_q <= '0;
            hit_found_q <= 1'b0;
            free_found_q <= 1'b0;
            state_q <= S_SCAN;
          end else if (rd_start_i) begin
            ptr_q <= idx_i;
            state_q <= S_RDWAIT;
          end
        end
        S_SCAN: begin
          if (ptr_q == IdxW'(TableEntries - 1)) state_q <= S_LAST;
          else ptr_q <= ptr_q + 1'b1;
        end
        S_LAST: state_q <= S_REREAD;
        // hit flag and index are final here; fetch the hit slot contents
        S_REREAD: state_q <= S_WRITE;
        S_WRITE: begin
          if (hit_found_q) begin
            status_o <= ifct_pkg::StHit;
          end else if (free_found_q) begin
            valid_q[free_q] <= 1'b1;
            status_o <= ifct_pkg::StNew;
          end else begin
            status_o <= ifct_pkg::StFull;
          end
          done_o <= 1'b1;
          state_q <= S_IDLE;
        end
        S_RDWAIT: state_q <= S_RDOUT;
        S_RDOUT: begin
          ent_valid_o <= valid_q[ptr_q];
          ent_addr_o <= valid_q[ptr_q] ? rkey : '0;
          ent_pkts_o <= valid_q[ptr_q] ? rpkt : '0;
          ent_bytes_o <= valid_q[ptr_q] ? rbyte : '0;
          valid_q[ptr_q] <= 1'b0;
          done_o <= 1'b1;
          state_q <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

FILE: hdl/ip_flow_counter_table.sv
// ip flow counter table top level: request decode, totals, output register
// uses ifct_pkg and ifct_table
//
// usage
//   one request beat on req_* (valid/ready) gives exactly one result beat on
//   res_* (valid/ready). packet updates scan both tables in parallel, one
//   slot per cycle from each table memory (single read port), then a hit
//   updates the matched slot or a miss claims the lowest free one.
//   one request is in work at a time; the rate of packet updates is set by
//   the slot scan over the table memory read port.
//   a hit needs its slot contents, so after the scan the hit slot is re-read once.
//   reset clears the valid flags and totals at once; no clearing pass.
//   a finished result sits in the output register; while the receiver stalls
//   no new request is taken.
`default_nettype none
module ip_flow_counter_table #(
  parameter int unsigned TableEntries = ifct_pkg::TableEntriesDef
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        req_valid_i,
  output logic             req_ready_o,
  input  wire logic [1:0]  req_type_i,
  input  wire logic [31:0] src_addr_i,
  input  wire logic [31:0] dst_addr_i,
  input  wire logic [15:0] wire_length_i,
  input  wire logic        table_select_i,
  input  wire logic [7:0]  entry_index_i,
  output logic             res_valid_o,
  input  wire logic        res_ready_i,
  output logic [1:0]       src_status_o,
  output logic [1:0]       dst_status_o,
  output logic             entry_valid_o,
  output logic [31:0]      entry_addr_o,
  output logic [31:0]      entry_packets_o,
  output logic [47:0]      entry_bytes_o,
  output logic [31:0]      total_packets_o,
  output logic [47:0]      total_bytes_o
);
  localparam int unsigned IdxW = (TableEntries > 1) ? $clog2(TableEntries) : 1;
  typedef enum logic [1:0] {T_IDLE, T_BUSY, T_OUT} state_e;

  state_e state_q;
  logic [1:0] type_q;
  logic [31:0] src_q, dst_q;
  logic [15:0] len_q;
  logic sel_q;
  logic [31:0] sum_pkt_q;
  logic [47:0] sum_byte_q;
  logic src_done_q, dst_done_q;

  logic accept;
  assign req_ready_o = (state_q == T_IDLE);
  assign accept = req_valid_i && req_ready_o;

  // index in range check, at full request width
  logic idx_ok;
  assign idx_ok = {24'd0, entry_index_i} < 32'(TableEntries);

  logic upd_go, src_rd_go, dst_rd_go;
  assign upd_go = accept && (req_type_i == ifct_pkg::ReqPacket);
  assign src_rd_go = accept && (req_type_i == ifct_pkg::ReqEntry) && idx_ok && !table_select_i;
  assign dst_rd_go = accept && (req_type_i == ifct_pkg::ReqEntry) && idx_ok && table_select_i;

  logic s_done, d_done, s_ev, d_ev;
  logic [1:0] s_st, d_st;
  logic [31:0] s_ad, d_ad, s_pk, d_pk;
  logic [47:0] s_by, d_by;

  // the scan runs after the accept, so the tables see the held request
  ifct_table #(.TableEntries(TableEntries)) u_src (
    .clk_i, .rst_ni, .upd_start_i(upd_go), .rd_start_i(src_rd_go),
    .addr_i(src_q), .len_i(len_q), .idx_i(IdxW'(entry_index_i)),
    .done_o(s_done), .status_o(s_st), .ent_valid_o(s_ev), .ent_addr_o(s_ad),
    .ent_pkts_o(s_pk), .ent_bytes_o(s_by)
  );
  ifct_table #(.TableEntries(TableEntries)) u_dst (
    .clk_i, .rst_ni, .upd_start_i(upd_go), .rd_start_i(dst_rd_go),
    .addr_i(dst_q), .len_i(len_q), .idx_i(IdxW'(entry_index_i)),
    .done_o(d_done), .status_o(d_st), .ent_valid_o(d_ev), .ent_addr_o(d_ad),
    .ent_pkts_o(d_pk), .ent_bytes_o(d_by)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= T_IDLE;
      res_valid_o <= 1'b0;
      sum_pkt_q <= '0;
      sum_byte_q <= '0;
      src_done_q <= 1'b0;
      dst_done_q <= 1'b0;
      type_q <= ifct_pkg::ReqPacket;
      sel_q <= 1'b0;
      src_q <= '0;
      dst_q <= '0;
      len_q <= '0;
      src_status_o <= ifct_pkg::StNone;
      dst_status_o <= ifct_pkg::StNone;
      entry_valid_o <= 1'b0;
      entry_addr_o <= '0;
      entry_packets_o <= '0;
      entry_bytes_o <= '0;
      total_packets_o <= '0;
      total_bytes_o <= '0;
    end else begin
      case (state_q)
        T_IDLE: begin
          if (accept) begin
            type_q <= req_type_i;
            sel_q <= table_select_i;
            src_q <= src_addr_i;
            dst_q <= dst_addr_i;
            len_q <= wire_length_i;
            src_done_q <= 1'b0;
            dst_done_q <= 1'b0;
            src_status_o <= ifct_pkg::StNone;
            dst_status_o <= ifct_pkg::StNone;
            entry_valid_o <= 1'b0;
            entry_addr_o <= '0;
            entry_packets_o <= '0;
            entry_bytes_o <= '0;
            total_packets_o <= '0;
            total_bytes_o <= '0;
            if (req_type_i == ifct_pkg::ReqPacket) begin
              sum_pkt_q <= ifct_pkg::sat_pkt(sum_pkt_q);
              sum_byte_q <= ifct_pkg::sat_byte(sum_byte_q, wire_length_i);
              state_q <= T_BUSY;
            end else if (src_rd_go || dst_rd_go) begin
              state_q <= T_BUSY;
            end else begin
              if (req_type_i == ifct_pkg::ReqTotals) begin
                total_packets_o <= sum_pkt_q;
                total_bytes_o <= sum_byte_q;
                sum_pkt_q <= '0;
                sum_byte_q <= '0;
              end
              res_valid_o <= 1'b1;
              state_q <= T_OUT;
            end
          end
        end
        T_BUSY: begin
          if (s_done) src_done_q <= 1'b1;
          if (d_done) dst_done_q <= 1'b1;
          if (type_q == ifct_pkg::ReqPacket) begin
            if ((s_done || src_done_q) && (d_done || dst_done_q)) begin
              src_status_o <= s_done ? s_st : src_status_o;
              dst_status_o <= d_done ? d_st : dst_status_o;
              res_valid_o <= 1'b1;
              state_q <= T_OUT;
            end else begin
              if (s_done) src_status_o <= s_st;
              if (d_done) dst_status_o <= d_st;
            end
          end else if (s_done || d_done) begin
            entry_valid_o <= sel_q ? d_ev : s_ev;
            entry_addr_o <= sel_q ? d_ad : s_ad;
            entry_packets_o <= sel_q ? d_pk : s_pk;
            entry_bytes_o <= sel_q ? d_by : s_by;
            res_valid_o <= 1'b1;
            state_q <= T_OUT;
          end
        end
        T_OUT: begin
          if (res_ready_i) begin
            res_valid_o <= 1'b0;
            state_q <= T_IDLE;
          end
        end
        default: state_q <= T_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire
